>>> hdl/combined_lcg_shuffle_rng_assert.svh
// Assertion macros for the combined LCG shuffle generator
`ifndef COMBINED_LCG_SHUFFLE_RNG_ASSERT_SVH
`define COMBINED_LCG_SHUFFLE_RNG_ASSERT_SVH

// same-cycle implication under synchronous active-low reset
`define CLSR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication under synchronous active-low reset
`define CLSR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> hdl/clsr_pkg.sv
// Constants and types shared by the combined LCG shuffle generator
package clsr_pkg;

    localparam int TABLE_DEPTH_DEF = 32;
    localparam int WARMUP_EXTRA    = 8;

    localparam logic [30:0] MOD_ONE  = 31'd2147483563;
    localparam logic [30:0] MOD_TWO  = 31'd2147483399;
    localparam logic [15:0] MUL_ONE  = 16'd40014;
    localparam logic [15:0] MUL_TWO  = 16'd40692;
    localparam logic [7:0]  FOLD_ONE = 8'd85;
    localparam logic [7:0]  FOLD_TWO = 8'd249;
    localparam logic [30:0] SEED_ONE = 31'd1;
    localparam logic [30:0] SEED_TWO = 31'd123456789;
    localparam logic [30:0] WRAP_ADD = 31'd2147483562;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WMUL,
        S_WRED,
        S_D0,
        S_MUL,
        S_RD,
        S_FIN
    } t_state;

endpackage

>>> hdl/clsr_modmul.sv
// Constant modular multiplier: registered product, then fold and reduce
module clsr_modmul #(
    parameter logic [15:0] MUL     = clsr_pkg::MUL_ONE,
    parameter logic [7:0]  FOLD    = clsr_pkg::FOLD_ONE,
    parameter logic [30:0] MODULUS = clsr_pkg::MOD_ONE
) (
    input  logic        i_clk,
    input  logic        i_start,
    input  logic [30:0] i_x,
    output logic [30:0] o_y
);

    logic [46:0] r_prod;
    logic [15:0] hi;
    logic [30:0] lo;
    logic [31:0] fold_sum;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_prod <= 47'(i_x) * 47'(MUL);
        end
    end

    always_comb begin
        hi       = r_prod[46:31];
        lo       = r_prod[30:0];
        fold_sum = 32'(hi) * 32'(FOLD) + 32'(lo);
        if (fold_sum >= 32'(MODULUS)) begin
            o_y = 31'(fold_sum - 32'(MODULUS));
        end else begin
            o_y = fold_sum[30:0];
        end
    end

endmodule

>>> hdl/clsr_index.sv
// Table index from previous output: reciprocal multiply, then one correction
module clsr_index #(
    parameter int TABLE_DEPTH = clsr_pkg::TABLE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_start,
    input  logic [30:0]                    i_prev,
    output logic [$clog2(TABLE_DEPTH)-1:0] o_idx
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int QW = IW + 1;
    localparam int RW = IW + 2;
    localparam int PW = QW + 31;
    localparam logic [30:0] IDX_DIV = 31'(1 + clsr_pkg::WRAP_ADD / TABLE_DEPTH);
    localparam longint unsigned TWO_POW = 64'd1 << 31;
    localparam logic [RW-1:0] IDX_RECIP = RW'(TWO_POW / IDX_DIV);

    logic [30+RW:0] prod;
    logic [QW-1:0]  r_q0;
    logic [30:0]    r_prev;
    logic [PW-1:0]  back;
    logic [PW-1:0]  rem;
    logic [QW-1:0]  q;

    assign prod = (31+RW)'(i_prev) * (31+RW)'(IDX_RECIP);

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q0   <= prod[31 +: QW];
            r_prev <= i_prev;
        end
    end

    always_comb begin
        back = PW'(r_q0) * PW'(IDX_DIV);
        rem  = PW'(r_prev) - back;
        q    = (rem >= PW'(IDX_DIV)) ? QW'(r_q0 + 1'b1) : r_q0;
        if (q >= QW'(TABLE_DEPTH)) begin
            o_idx = IW'(TABLE_DEPTH - 1);
        end else begin
            o_idx = q[IW-1:0];
        end
    end

endmodule

>>> hdl/clsr_table.sv
// Shuffle table memory with per-entry valid bits; unwritten entries read zero
module clsr_table #(
    parameter int TABLE_DEPTH = clsr_pkg::TABLE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_we,
    input  logic [$clog2(TABLE_DEPTH)-1:0] i_waddr,
    input  logic [30:0]                    i_wdata,
    input  logic                           i_re,
    input  logic [$clog2(TABLE_DEPTH)-1:0] i_raddr,
    output logic [30:0]                    o_rdata
);

    logic [30:0]            mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] r_valid;
    logic [30:0]            r_rdata;
    logic                   r_rvalid;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_rvalid <= r_valid[i_raddr];
            end
        end
    end

    assign o_rdata = r_rvalid ? r_rdata : 31'd0;

endmodule

>>> hdl/combined_lcg_shuffle_rng.sv
// Combined two-modulus LCG with shuffle table, one 31-bit draw per request beat.
// A draw without restart runs from accept to result as follows: the accept cycle
// loads both multiplier products and the index reciprocal product, S_MUL
// reduces them, S_RD reads and writes the shuffle table memory, and S_FIN
// combines the table entry with the second generator into the output
// register once the output is free. A restart beat first runs TABLE_DEPTH+8
// warm-up steps through the first generator's multiply-reduce unit, each an
// S_WMUL and an S_WRED state. The table needs no clearing pass.
module combined_lcg_shuffle_rng #(
    parameter int TABLE_DEPTH = clsr_pkg::TABLE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [0] restart, [7:1] zero
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [30:0] draw, [31] zero
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [30:0] i_cfg_data
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + clsr_pkg::WARMUP_EXTRA);

    clsr_pkg::t_state r_state, n_state;
    logic [30:0]   r_seed, n_seed;
    logic [30:0]   r_g1, n_g1;
    logic [30:0]   r_g2, n_g2;
    logic [30:0]   r_prev, n_prev;
    logic          r_out_valid, n_out_valid;
    logic [30:0]   r_draw, n_draw;
    logic [IW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_wcnt, n_wcnt;

    logic          accept;
    logic [30:0]   seed_used;
    logic          m1_start;
    logic          m2_start;
    logic [30:0]   m1_y;
    logic [30:0]   m2_y;
    logic [IW-1:0] idx_y;
    logic          tbl_we;
    logic [IW-1:0] tbl_waddr;
    logic [30:0]   tbl_wdata;
    logic          tbl_re;
    logic [30:0]   tbl_rdata;
    logic [30:0]   result;

    clsr_modmul #(
        .MUL     (clsr_pkg::MUL_ONE),
        .FOLD    (clsr_pkg::FOLD_ONE),
        .MODULUS (clsr_pkg::MOD_ONE)
    ) u_mm_one (
        .i_clk   (i_clk),
        .i_start (m1_start),
        .i_x     (r_g1),
        .o_y     (m1_y)
    );

    clsr_modmul #(
        .MUL     (clsr_pkg::MUL_TWO),
        .FOLD    (clsr_pkg::FOLD_TWO),
        .MODULUS (clsr_pkg::MOD_TWO)
    ) u_mm_two (
        .i_clk   (i_clk),
        .i_start (m2_start),
        .i_x     (r_g2),
        .o_y     (m2_y)
    );

    clsr_index #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_index (
        .i_clk   (i_clk),
        .i_start (m2_start),
        .i_prev  (r_prev),
        .o_idx   (idx_y)
    );

    clsr_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (tbl_wdata),
        .i_re    (tbl_re),
        .i_raddr (r_idx),
        .o_rdata (tbl_rdata)
    );

    assign o_s_tready  = (r_state == clsr_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = {1'b0, r_draw};
    assign accept      = i_s_tvalid && o_s_tready;
    assign seed_used   = (r_seed == 31'd0) ? 31'd1 : r_seed;

    always_comb begin
        if (tbl_rdata > r_g2) begin
            result = tbl_rdata - r_g2;
        end else begin
            result = clsr_pkg::WRAP_ADD - (r_g2 - tbl_rdata);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_seed      = r_seed;
        n_g1        = r_g1;
        n_g2        = r_g2;
        n_prev      = r_prev;
        n_draw      = r_draw;
        n_idx       = r_idx;
        n_wcnt      = r_wcnt;
        n_out_valid = r_out_valid;
        m1_start    = 1'b0;
        m2_start    = 1'b0;
        tbl_we      = 1'b0;
        tbl_waddr   = r_idx;
        tbl_wdata   = r_g1;
        tbl_re      = 1'b0;

        if (i_cfg_valid) begin
            n_seed = i_cfg_data;
        end
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            clsr_pkg::S_IDLE: begin
                if (accept) begin
                    if (i_s_tdata[0]) begin
                        n_g1    = seed_used;
                        n_g2    = seed_used;
                        n_wcnt  = CW'(TABLE_DEPTH + clsr_pkg::WARMUP_EXTRA - 1);
                        n_state = clsr_pkg::S_WMUL;
                    end else begin
                        m1_start = 1'b1;
                        m2_start = 1'b1;
                        n_state  = clsr_pkg::S_MUL;
                    end
                end
            end
            clsr_pkg::S_WMUL: begin
                m1_start = 1'b1;
                n_state  = clsr_pkg::S_WRED;
            end
            clsr_pkg::S_WRED: begin
                n_g1      = m1_y;
                tbl_we    = (r_wcnt < CW'(TABLE_DEPTH));
                tbl_waddr = r_wcnt[IW-1:0];
                tbl_wdata = m1_y;
                if (r_wcnt == '0) begin
                    n_prev  = m1_y;
                    n_state = clsr_pkg::S_D0;
                end else begin
                    n_wcnt  = r_wcnt - 1'b1;
                    n_state = clsr_pkg::S_WMUL;
                end
            end
            clsr_pkg::S_D0: begin
                m1_start = 1'b1;
                m2_start = 1'b1;
                n_state  = clsr_pkg::S_MUL;
            end
            clsr_pkg::S_MUL: begin
                n_g1    = m1_y;
                n_g2    = m2_y;
                n_idx   = idx_y;
                n_state = clsr_pkg::S_RD;
            end
            clsr_pkg::S_RD: begin
                tbl_re  = 1'b1;
                tbl_we  = 1'b1;
                n_state = clsr_pkg::S_FIN;
            end
            clsr_pkg::S_FIN: begin
                if (!r_out_valid || i_m_tready) begin
                    n_draw      = result;
                    n_prev      = result;
                    n_out_valid = 1'b1;
                    n_state     = clsr_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = clsr_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= clsr_pkg::S_IDLE;
            r_seed      <= clsr_pkg::SEED_ONE;
            r_g1        <= clsr_pkg::SEED_ONE;
            r_g2        <= clsr_pkg::SEED_TWO;
            r_prev      <= 31'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_seed      <= n_seed;
            r_g1        <= n_g1;
            r_g2        <= n_g2;
            r_prev      <= n_prev;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_draw <= n_draw;
        r_idx  <= n_idx;
        r_wcnt <= n_wcnt;
    end

`include "combined_lcg_shuffle_rng_assert.svh"

    `CLSR_ASSERT_IMPL(a_draw_range, i_clk, i_rst_n, o_m_tvalid, (o_m_tdata[30:0] != 31'd0) && (o_m_tdata[30:0] <= clsr_pkg::WRAP_ADD))
    `CLSR_ASSERT_IMPL(a_prev_below_mod, i_clk, i_rst_n, 1'b1, r_prev < clsr_pkg::MOD_ONE)
    `CLSR_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, accept, (r_state == clsr_pkg::S_MUL) || (r_state == clsr_pkg::S_WMUL))
    `CLSR_ASSERT_IMPL(a_g2_reduced, i_clk, i_rst_n, r_state == clsr_pkg::S_FIN, r_g2 < clsr_pkg::MOD_TWO)

endmodule

>>> test/tb.sv
// Self-checking testbench for the combined LCG shuffle random source
`timescale 1ns / 1ps

module tb;

    localparam int          DEPTH     = clsr_pkg::TABLE_DEPTH_DEF;
    localparam logic [30:0] SLOT_DIV  = clsr_pkg::WRAP_ADD / 31'(DEPTH) + 31'd1;
    localparam int          PHASES    = 10;
    localparam int          HOLD_OFF  = 300;
    localparam int          IDLE_PAD  = 4;
    localparam int          END_PAD   = 100;
    localparam int          MAX_SHOWN = 10;
    localparam int          N_ROWS    = 18;

    typedef struct packed {
        logic        set_seed;
        logic [30:0] seed;
        logic        restart;
        logic        known;
        logic [30:0] draw;
    } t_row;

    // the first draw after reset reads a cleared entry, so it is the wrapped
    // complement of the second generator after one step
    localparam t_row ROWS [N_ROWS] = '{
        '{1'b0, 31'd0,              1'b0, 1'b1, 31'd1407495835},
        '{1'b0, 31'd0,              1'b0, 1'b0, 31'd0},
        '{1'b0, 31'd0,              1'b0, 1'b0, 31'd0},
        '{1'b0, 31'd0,              1'b1, 1'b0, 31'd0},
        '{1'b0, 31'd0,              1'b0, 1'b0, 31'd0},
        '{1'b1, 31'd0,              1'b1, 1'b0, 31'd0},
        '{1'b0, 31'd0,              1'b0, 1'b0, 31'd0},
        '{1'b1, clsr_pkg::WRAP_ADD, 1'b1, 1'b0, 31'd0},
        '{1'b1, clsr_pkg::MOD_ONE,  1'b1, 1'b0, 31'd0},
        '{1'b0, 31'd0,              1'b0, 1'b0, 31'd0},
        '{1'b1, clsr_pkg::MOD_TWO,  1'b1, 1'b0, 31'd0},
        '{1'b0, 31'd0,              1'b0, 1'b0, 31'd0},
        '{1'b1, 31'h7FFFFFFF,       1'b1, 1'b0, 31'd0},
        '{1'b0, 31'd0,              1'b0, 1'b0, 31'd0},
        '{1'b1, 31'h2AAAAAAA,       1'b1, 1'b0, 31'd0},
        '{1'b0, 31'd0,              1'b1, 1'b0, 31'd0},
        '{1'b1, 31'h55555555,       1'b1, 1'b0, 31'd0},
        '{1'b0, 31'd0,              1'b0, 1'b0, 31'd0}
    };

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_s_tvalid  = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata   = 8'd0;   // [0] restart, [7:1] zero
    logic        o_m_tvalid;
    logic        i_m_tready  = 1'b0;
    logic [31:0] o_m_tdata;            // [30:0] draw, [31] zero
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [30:0] i_cfg_data  = 31'd0;

    // predicted generator state
    logic [30:0] seed_reg;
    logic [30:0] gen_one;
    logic [30:0] gen_two;
    logic [30:0] last_draw;
    logic [30:0] shuffle_tab [DEPTH];

    logic [30:0] expected_draws [$];
    int          fail_count    = 0;
    int          draws_checked = 0;
    int          requests_sent = 0;
    int          reseeds_sent  = 0;
    int          seed_writes   = 0;
    bit          tx_calm       = 1'b0;
    bit          hold_off_req  = 1'b0;

    combined_lcg_shuffle_rng dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [30:0] lcg_mul(input logic [30:0] x, input logic [15:0] a,
                                            input logic [30:0] m);
        logic [63:0] prod;
        prod = 64'(x) * 64'(a);
        return 31'(prod % 64'(m));
    endfunction

    function automatic void clear_generator();
        seed_reg  = clsr_pkg::SEED_ONE;
        gen_one   = clsr_pkg::SEED_ONE;
        gen_two   = clsr_pkg::SEED_TWO;
        last_draw = 31'd0;
        foreach (shuffle_tab[k]) shuffle_tab[k] = 31'd0;
    endfunction

    function automatic logic [30:0] next_draw(input logic restart);
        logic [30:0] s;
        logic [30:0] slot;
        logic [30:0] entry;
        logic [30:0] draw;
        if (restart) begin
            s = (seed_reg == 31'd0) ? 31'd1 : seed_reg;
            gen_one = s;
            gen_two = s;
            for (int n = DEPTH + clsr_pkg::WARMUP_EXTRA - 1; n >= 0; n--) begin
                gen_one = lcg_mul(gen_one, clsr_pkg::MUL_ONE, clsr_pkg::MOD_ONE);
                if (n < DEPTH) shuffle_tab[n] = gen_one;
            end
            last_draw = shuffle_tab[0];
        end
        gen_one = lcg_mul(gen_one, clsr_pkg::MUL_ONE, clsr_pkg::MOD_ONE);
        gen_two = lcg_mul(gen_two, clsr_pkg::MUL_TWO, clsr_pkg::MOD_TWO);
        slot = last_draw / SLOT_DIV;
        if (slot >= 31'(DEPTH)) slot = 31'(DEPTH - 1);
        entry = shuffle_tab[slot];
        shuffle_tab[slot] = gen_one;
        if (entry > gen_two) draw = entry - gen_two;
        else draw = clsr_pkg::WRAP_ADD - (gen_two - entry);
        last_draw = draw;
        return draw;
    endfunction

    function automatic void report_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_SHOWN) $display("ERROR: %s", msg);
    endfunction

    function automatic int pick_gap(input bit calm);
        return calm ? 0 : $urandom_range(0, 5);
    endfunction

    // call at a falling edge; returns at a falling edge with valid still high
    task automatic offer_request(input logic restart, input logic known,
                                 input logic [30:0] typed_draw);
        int          gap;
        logic [30:0] predicted;
        gap = pick_gap(tx_calm);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {7'd0, restart};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        predicted = next_draw(restart);
        expected_draws.push_back(known ? typed_draw : predicted);
        requests_sent++;
        if (restart) reseeds_sent++;
        @(negedge i_clk);
    endtask

    // drop the request and let every pending draw come out
    task automatic settle();
        i_s_tvalid <= 1'b0;
        while (expected_draws.size() != 0) @(negedge i_clk);
        repeat (IDLE_PAD) @(negedge i_clk);
    endtask

    task automatic write_seed(input logic [30:0] value);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        seed_reg = value;
        seed_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [30:0] pick_seed();
        case ($urandom_range(0, 9))
            0: return 31'd0;
            1: return 31'd1;
            2: return clsr_pkg::WRAP_ADD;
            3: return clsr_pkg::MOD_ONE;
            4: return clsr_pkg::MOD_TWO;
            5: return 31'h7FFFFFFF;
            default: return 31'($urandom);
        endcase
    endfunction

    task automatic check_draw(input logic [31:0] beat);
        logic [30:0] want;
        if (expected_draws.size() == 0) begin
            report_failure($sformatf("unexpected draw %0d", beat[30:0]));
            return;
        end
        want = expected_draws.pop_front();
        draws_checked++;
        if (beat[30:0] !== want)
            report_failure($sformatf("draw %0d: expected %0d, got %0d",
                                     draws_checked, want, beat[30:0]));
    endtask

    // result side: random stalls, stretches of full rate, one long hold-off
    initial begin
        int  wait_cycles;
        int  beats;
        bit  rx_calm;
        beats   = 0;
        rx_calm = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (beats % 64 == 0) rx_calm = ($urandom_range(0, 3) == 0);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                wait_cycles  = HOLD_OFF;
            end else begin
                wait_cycles = pick_gap(rx_calm);
            end
            if (wait_cycles > 0) begin
                i_m_tready <= 1'b0;
                repeat (wait_cycles) @(negedge i_clk);
            end
            i_m_tready <= 1'b1;
            @(posedge i_clk);
            while (!o_m_tvalid) @(posedge i_clk);
            check_draw(o_m_tdata);
            beats++;
        end
    end

    initial begin
        int   count;
        logic restart;
        clear_generator();
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int r = 0; r < N_ROWS; r++) begin
            if (ROWS[r].set_seed) write_seed(ROWS[r].seed);
            offer_request(ROWS[r].restart, ROWS[r].known, ROWS[r].draw);
        end

        for (int p = 0; p < PHASES; p++) begin
            write_seed(pick_seed());
            tx_calm = ($urandom_range(0, 3) == 0);
            count   = $urandom_range(100, 150);
            for (int i = 0; i < count; i++) begin
                if (i == 0) restart = ($urandom_range(0, 4) != 0);
                else restart = ($urandom_range(0, 19) == 0);
                if (p == 2 && i == 30) hold_off_req = 1'b1;
                offer_request(restart, 1'b0, 31'd0);
            end
        end

        settle();
        repeat (END_PAD) @(negedge i_clk);
        if (expected_draws.size() != 0)
            report_failure($sformatf("%0d draws never arrived", expected_draws.size()));

        $display("Checked %0d draws from %0d requests, %0d of them reseeding,",
                 draws_checked, requests_sent, reseeds_sent);
        $display("across %0d seed writes including zero, both moduli and all ones.",
                 seed_writes);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d failures", fail_count);
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Timeout waiting for handshakes");
        $display("Test completed with failures");
        $finish;
    end

endmodule
